// ----- rtl/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared field widths, codes and controller/datapath command types for the
// bounded vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;

    // item modes
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // what an accepted item turns into once its checks are done
    typedef enum logic [2:0] {
        ACT_REJECT,
        ACT_READ,
        ACT_WRITE,
        ACT_PUSH,
        ACT_POP,
        ACT_INSERT,
        ACT_ERASE,
        ACT_RESIZE
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_LOOP,
        S_INS_MOVE,
        S_ERA_LOOP,
        S_ERA_MOVE,
        S_FILL,
        S_FINISH
    } state_t;

    // memory read address select
    typedef enum logic [1:0] {
        RD_INDEX,
        RD_BELOW,
        RD_ABOVE
    } rd_sel_t;

    // memory write address/data select
    typedef enum logic [1:0] {
        WR_AT_INDEX,
        WR_AT_COUNT,
        WR_PTR_RDATA,
        WR_PTR_VALUE
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    ptr_init;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    commit;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    more;
        logic    out_free;
    } stat_t;

endpackage

// ----- rtl/bvs_in_if.sv -----
// ----------------------------------------------------------------------------
// bvs_in_if
// Item channel of the bounded vector store: valid/ready plus item payload.
// ----------------------------------------------------------------------------
interface bvs_in_if;

    logic                                valid;
    logic                                ready;
    logic        [bvs_pkg::MODE_W-1:0]   mode;
    logic        [bvs_pkg::INDEX_W-1:0]  index;
    logic signed [bvs_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);

endinterface

// ----- rtl/bvs_out_if.sv -----
// ----------------------------------------------------------------------------
// bvs_out_if
// Result channel of the bounded vector store: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface bvs_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bvs_pkg::VALUE_W-1:0]   read_value;
    logic        [bvs_pkg::LEN_W-1:0]     length;
    logic        [bvs_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output read_value, output length, output status,
                    input ready);
    modport sink   (input valid, input read_value, input length, input status,
                    output ready);

endinterface

// ----- rtl/bounded_vector_store_top.sv -----
// ----------------------------------------------------------------------------
// bounded_vector_store_top
// Ordered array of signed 32-bit entries with a live length and a fixed
// capacity, driven by read/write/push/pop/insert/erase/resize items.
// ----------------------------------------------------------------------------
// usage:
//   items   - item channel (mode, index, value), one beat per item
//   results - result channel (read_value, length, status), one beat per item
//   every item gives exactly one result beat, in item order
// an item is latched on accept, checked in a decide step, runs its pass, if
// any, and loads the result register in a finish step; the earliest next
// accept is in the cycle after that load; only these items run a pass:
//   insert at index i with n live entries: moves i..n-1 up one, writes at i
//   erase at index i with n live entries: moves i+1..n-1 down one
//   resize from n to m entries: fills entries n..m-1 with the item value
//   every entry move is one read then one write on the entry memory,
//   a fill is one write per cycle
// the item channel is ready again as soon as the result sits in the output
// register, so a new item is accepted while the previous result waits
// reset clears the live length and the result valid; entry contents are
// undefined until written and need no clearing pass
// a stalled result receiver holds the finished item in its last step, and no
// further item is taken until the result register frees up
// ----------------------------------------------------------------------------
module bounded_vector_store_top #(
    parameter int CAPACITY = 256
) (
    input logic  clk,
    input logic  rst_n,
    bvs_in_if.sink    items,
    bvs_out_if.source results
);

    // command and status between the sequencer and the datapath
    bvs_pkg::cmd_t  cmd;
    bvs_pkg::stat_t stat;

    // sequencer: accept, move and fill passes, result hand-off
    bvs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: entry memory, live length, checks and result register
    bvs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mode        (items.mode),
        .in_index       (items.index),
        .in_value       (items.value),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_read_value (results.read_value),
        .out_length     (results.length),
        .out_status     (results.status)
    );

endmodule

// ----- rtl/bvs_datapath.sv -----
// ----------------------------------------------------------------------------
// bvs_datapath
// Entry memory, live count, item checks, move pointer and result register.
// ----------------------------------------------------------------------------
module bvs_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic        [bvs_pkg::MODE_W-1:0]   in_mode,
    input  logic        [bvs_pkg::INDEX_W-1:0]  in_index,
    input  logic signed [bvs_pkg::VALUE_W-1:0]  in_value,
    input  bvs_pkg::cmd_t                       cmd,
    output bvs_pkg::stat_t                      stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bvs_pkg::VALUE_W-1:0]  out_read_value,
    output logic        [bvs_pkg::LEN_W-1:0]    out_length,
    output logic        [bvs_pkg::STATUS_W-1:0] out_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > bvs_pkg::INDEX_W) ? CW : bvs_pkg::INDEX_W;

    logic        [bvs_pkg::MODE_W-1:0]   mode_reg;
    logic        [bvs_pkg::INDEX_W-1:0]  index_reg;
    logic signed [bvs_pkg::VALUE_W-1:0]  value_reg;
    logic        [CW-1:0]                count_reg;
    logic        [CW-1:0]                count_next;
    logic        [CW-1:0]                ptr_reg;
    logic        [CW-1:0]                ptr_next;
    logic signed [bvs_pkg::VALUE_W-1:0]  rdata_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [bvs_pkg::VALUE_W-1:0]  out_value_reg;
    logic        [bvs_pkg::LEN_W-1:0]    out_len_reg;
    logic        [bvs_pkg::STATUS_W-1:0] out_status_reg;

    logic signed [bvs_pkg::VALUE_W-1:0]  mem [CAPACITY];

    logic        [XW-1:0]                idx_x;
    logic        [XW-1:0]                cnt_x;
    logic        [XW-1:0]                ptr_x;
    logic        [XW-1:0]                cap_x;
    logic        [XW:0]                  ptr_p1_x;
    logic        [CW-1:0]                ptr_m1;
    logic        [CW-1:0]                ptr_p1;
    logic        [bvs_pkg::STATUS_W-1:0] st;
    bvs_pkg::action_t                    act;
    logic                                more;
    logic        [AW-1:0]                rd_addr;
    logic        [AW-1:0]                wr_addr;
    logic signed [bvs_pkg::VALUE_W-1:0]  wr_data;

    assign idx_x    = XW'(index_reg);
    assign cnt_x    = XW'(count_reg);
    assign ptr_x    = XW'(ptr_reg);
    assign cap_x    = XW'(CAPACITY);
    assign ptr_p1_x = {1'b0, ptr_x} + (XW + 1)'(1);
    assign ptr_m1   = ptr_reg - CW'(1);
    assign ptr_p1   = ptr_reg + CW'(1);

    // item checks
    always_comb
    begin
        st  = bvs_pkg::ST_DONE;
        act = bvs_pkg::ACT_REJECT;
        unique case (mode_reg)
            bvs_pkg::MODE_READ:
            begin
                if (idx_x < cnt_x) act = bvs_pkg::ACT_READ;
                else               st  = bvs_pkg::ST_BAD;
            end
            bvs_pkg::MODE_WRITE:
            begin
                if (idx_x < cnt_x) act = bvs_pkg::ACT_WRITE;
                else               st  = bvs_pkg::ST_BAD;
            end
            bvs_pkg::MODE_PUSH:
            begin
                if (cnt_x >= cap_x) st  = bvs_pkg::ST_FULL;
                else                act = bvs_pkg::ACT_PUSH;
            end
            bvs_pkg::MODE_POP:
            begin
                if (count_reg == '0) st  = bvs_pkg::ST_BAD;
                else                 act = bvs_pkg::ACT_POP;
            end
            bvs_pkg::MODE_INSERT:
            begin
                if (idx_x > cnt_x)       st  = bvs_pkg::ST_BAD;
                else if (cnt_x >= cap_x) st  = bvs_pkg::ST_FULL;
                else                     act = bvs_pkg::ACT_INSERT;
            end
            bvs_pkg::MODE_ERASE:
            begin
                if (idx_x >= cnt_x) st  = bvs_pkg::ST_BAD;
                else                act = bvs_pkg::ACT_ERASE;
            end
            bvs_pkg::MODE_RESIZE:
            begin
                if (idx_x > cap_x) st  = bvs_pkg::ST_FULL;
                else               act = bvs_pkg::ACT_RESIZE;
            end
            default:
            begin
                st = bvs_pkg::ST_BAD;
            end
        endcase
    end

    // live count after the item
    always_comb
    begin
        unique case (act)
            bvs_pkg::ACT_PUSH,
            bvs_pkg::ACT_INSERT: count_next = count_reg + CW'(1);
            bvs_pkg::ACT_POP,
            bvs_pkg::ACT_ERASE:  count_next = count_reg - CW'(1);
            bvs_pkg::ACT_RESIZE: count_next = CW'(idx_x);
            default:             count_next = count_reg;
        endcase
    end

    // loop condition of the moving and filling passes
    always_comb
    begin
        unique case (act)
            bvs_pkg::ACT_INSERT: more = (ptr_x > idx_x);
            bvs_pkg::ACT_ERASE:  more = (ptr_p1_x < {1'b0, cnt_x});
            bvs_pkg::ACT_RESIZE: more = (ptr_x < idx_x);
            default:             more = 1'b0;
        endcase
    end

    assign stat.act      = act;
    assign stat.more     = more;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (cmd.rd_sel)
            bvs_pkg::RD_INDEX: rd_addr = idx_x[AW-1:0];
            bvs_pkg::RD_BELOW: rd_addr = ptr_m1[AW-1:0];
            bvs_pkg::RD_ABOVE: rd_addr = ptr_p1[AW-1:0];
            default:           rd_addr = idx_x[AW-1:0];
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            bvs_pkg::WR_AT_INDEX:
            begin
                wr_addr = idx_x[AW-1:0];
                wr_data = value_reg;
            end
            bvs_pkg::WR_AT_COUNT:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = value_reg;
            end
            bvs_pkg::WR_PTR_RDATA:
            begin
                wr_addr = ptr_reg[AW-1:0];
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = ptr_reg[AW-1:0];
                wr_data = value_reg;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.ptr_init)
        begin
            ptr_next = (act == bvs_pkg::ACT_ERASE) ? CW'(idx_x) : count_reg;
        end
        else if (cmd.ptr_inc) ptr_next = ptr_p1;
        else if (cmd.ptr_dec) ptr_next = ptr_m1;
        else                  ptr_next = ptr_reg;
    end

    always_comb
    begin
        priority if (cmd.commit) out_valid_next = 1'b1;
        else if (out_ready)      out_valid_next = 1'b0;
        else                     out_valid_next = out_valid_reg;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // item latch, pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            index_reg <= in_index;
            value_reg <= in_value;
        end
        ptr_reg <= ptr_next;
        if (cmd.commit)
        begin
            out_value_reg  <= (act == bvs_pkg::ACT_READ) ? rdata_reg : '0;
            out_len_reg    <= bvs_pkg::LEN_W'(count_next);
            out_status_reg <= st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_read_value = out_value_reg;
    assign out_length     = out_len_reg;
    assign out_status     = out_status_reg;

endmodule

// ----- rtl/bvs_controller.sv -----
// ----------------------------------------------------------------------------
// bvs_controller
// Sequencer of the bounded vector store: item accept, entry moves and fills,
// result hand-off.
// ----------------------------------------------------------------------------
module bvs_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bvs_pkg::stat_t stat,
    output bvs_pkg::cmd_t  cmd
);

    bvs_pkg::state_t state_reg;
    bvs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bvs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bvs_pkg::S_IDLE:
            begin
                if (in_valid) state_next = bvs_pkg::S_DECIDE;
            end
            bvs_pkg::S_DECIDE:
            begin
                unique case (stat.act)
                    bvs_pkg::ACT_INSERT: state_next = bvs_pkg::S_INS_LOOP;
                    bvs_pkg::ACT_ERASE:  state_next = bvs_pkg::S_ERA_LOOP;
                    bvs_pkg::ACT_RESIZE: state_next = bvs_pkg::S_FILL;
                    default:             state_next = bvs_pkg::S_FINISH;
                endcase
            end
            bvs_pkg::S_INS_LOOP:
            begin
                state_next = stat.more ? bvs_pkg::S_INS_MOVE : bvs_pkg::S_FINISH;
            end
            bvs_pkg::S_INS_MOVE:
            begin
                state_next = bvs_pkg::S_INS_LOOP;
            end
            bvs_pkg::S_ERA_LOOP:
            begin
                state_next = stat.more ? bvs_pkg::S_ERA_MOVE : bvs_pkg::S_FINISH;
            end
            bvs_pkg::S_ERA_MOVE:
            begin
                state_next = bvs_pkg::S_ERA_LOOP;
            end
            bvs_pkg::S_FILL:
            begin
                if (!stat.more) state_next = bvs_pkg::S_FINISH;
            end
            bvs_pkg::S_FINISH:
            begin
                if (stat.out_free) state_next = bvs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bvs_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bvs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bvs_pkg::S_DECIDE:
            begin
                unique case (stat.act)
                    bvs_pkg::ACT_READ:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rd_sel = bvs_pkg::RD_INDEX;
                    end
                    bvs_pkg::ACT_WRITE:
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.wr_sel = bvs_pkg::WR_AT_INDEX;
                    end
                    bvs_pkg::ACT_PUSH:
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.wr_sel = bvs_pkg::WR_AT_COUNT;
                    end
                    bvs_pkg::ACT_INSERT,
                    bvs_pkg::ACT_ERASE,
                    bvs_pkg::ACT_RESIZE:
                    begin
                        cmd.ptr_init = 1'b1;
                    end
                    default:
                    begin
                        cmd.ptr_init = 1'b0;
                    end
                endcase
            end
            bvs_pkg::S_INS_LOOP:
            begin
                if (stat.more)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = bvs_pkg::RD_BELOW;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_sel = bvs_pkg::WR_AT_INDEX;
                end
            end
            bvs_pkg::S_INS_MOVE:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = bvs_pkg::WR_PTR_RDATA;
                cmd.ptr_dec = 1'b1;
            end
            bvs_pkg::S_ERA_LOOP:
            begin
                cmd.mem_rd = stat.more;
                cmd.rd_sel = bvs_pkg::RD_ABOVE;
            end
            bvs_pkg::S_ERA_MOVE:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = bvs_pkg::WR_PTR_RDATA;
                cmd.ptr_inc = 1'b1;
            end
            bvs_pkg::S_FILL:
            begin
                cmd.mem_wr  = stat.more;
                cmd.wr_sel  = bvs_pkg::WR_PTR_VALUE;
                cmd.ptr_inc = stat.more;
            end
            bvs_pkg::S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
